FILE: design/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int BPA_MAX_PAGES  = 65536;
  localparam int BPA_PAGE_BYTES = 4096;
  // bitmap word index width for the default page count
  localparam int BPA_WIDX_W     = 10;

  localparam int BPA_ADDR_W = 64;
  localparam int BPA_PCNT_W = 17;
  localparam int BPA_OP_W   = 2;
  localparam int BPA_STS_W  = 2;
  localparam int BPA_CIDX_W = 1;

  localparam logic [BPA_CIDX_W-1:0] CFG_REGION_BASE = 1'b0;
  localparam logic [BPA_CIDX_W-1:0] CFG_PAGE_COUNT  = 1'b1;

  typedef enum logic [BPA_OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } bpa_op_t;

  typedef enum logic [BPA_STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_NOMEM = 2'd1,
    STS_RANGE = 2'd2
  } bpa_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_CLR,
    S_INIT_SWEEP,
    S_ALC_SRCH1,
    S_ALC_SRCH2,
    S_ALC_READ,
    S_ALC_MOD,
    S_ALC_ADDR,
    S_FREE_SUB,
    S_FREE_CHK,
    S_FREE_MOD,
    S_DONE
  } bpa_state_t;

  // one access to the bitmap word store and its non-full flag
  typedef struct packed {
    logic clr_all;
    logic we;
    logic re;
    logic nonfull;
  } bpa_acc_t;

  typedef struct packed {
    logic found;
    logic nonfull;
  } bpa_sum_sts_t;

  function automatic logic [5:0] bpa_lowest_set(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/bpa_chan_if.sv
`default_nettype none
interface bpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::BPA_OP_W-1:0]     opcode;
  logic [bpa_pkg::BPA_ADDR_W-1:0]   page_address;

  modport source (output valid, output opcode, output page_address, input ready);
  modport sink   (input valid, input opcode, input page_address, output ready);
endinterface

interface bpa_out_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::BPA_ADDR_W-1:0]   alloc_address;
  logic [bpa_pkg::BPA_STS_W-1:0]    status;

  modport source (output valid, output alloc_address, output status, input ready);
  modport sink   (input valid, input alloc_address, input status, output ready);
endinterface
`default_nettype wire

FILE: design/bpa_bitmap_mem.sv
`default_nettype none
module bpa_bitmap_mem #(
  parameter int WIDX_W = bpa_pkg::BPA_WIDX_W
) (
  input  wire logic              clk,
  input  wire bpa_pkg::bpa_acc_t acc,
  input  wire logic [WIDX_W-1:0] acc_idx,
  input  wire logic [63:0]       wdata,
  output logic [63:0]            rdata
);
  import bpa_pkg::*;

  localparam int DEPTH = 2 ** WIDX_W;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (acc.we) mem[acc_idx] <= wdata;
    if (acc.re) rdata_r <= mem[acc_idx];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/bpa_summary.sv
`default_nettype none
module bpa_summary #(
  parameter int WIDX_W = bpa_pkg::BPA_WIDX_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bpa_pkg::bpa_acc_t     acc,
  input  wire logic [WIDX_W-1:0]     acc_idx,
  output bpa_pkg::bpa_sum_sts_t      sts,
  output logic [WIDX_W-1:0]          found_idx
);
  import bpa_pkg::*;

  localparam int DEPTH  = 2 ** WIDX_W;
  localparam int GRP_W  = WIDX_W - 6;
  localparam int GROUPS = 2 ** GRP_W;

  // a clear flag means the word is all ones, whatever the ram holds
  logic [DEPTH-1:0]  sum_r;
  logic              nonfull_r;
  logic [GROUPS-1:0] grp_any;
  logic              grp_hit;
  logic [GRP_W-1:0]  grp_sel;
  logic              grp_found_r;
  logic [GRP_W-1:0]  grp_idx_r;
  logic [63:0]       grp_slice;
  logic              word_found_r;
  logic [WIDX_W-1:0] word_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (acc.clr_all) begin
      sum_r <= '0;
    end else if (acc.we) begin
      sum_r[acc_idx] <= acc.nonfull;
    end
  end

  always_ff @(posedge clk) begin
    if (acc.re) nonfull_r <= sum_r[acc_idx];
  end

  // first stage: lowest group of 64 words holding a non-full word
  always_comb begin
    grp_hit = 1'b0;
    grp_sel = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |sum_r[g*64 +: 64];
    end
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_hit = 1'b1;
        grp_sel = GRP_W'(g);
      end
    end
  end

  assign grp_slice = sum_r[{grp_idx_r, 6'b0} +: 64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_found_r  <= 1'b0;
      word_found_r <= 1'b0;
    end else begin
      grp_found_r  <= grp_hit;
      word_found_r <= grp_found_r && (|grp_slice);
    end
  end

  always_ff @(posedge clk) begin
    grp_idx_r  <= grp_sel;
    word_idx_r <= {grp_idx_r, bpa_lowest_set(grp_slice)};
  end

  assign sts.found   = word_found_r;
  assign sts.nonfull = nonfull_r;
  assign found_idx   = word_idx_r;

endmodule
`default_nettype wire

FILE: design/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl #(
  parameter int MAX_PAGES  = bpa_pkg::BPA_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::BPA_PAGE_BYTES,
  parameter int WIDX_W     = bpa_pkg::BPA_WIDX_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bpa_pkg::BPA_OP_W-1:0]     in_opcode,
  input  wire logic [bpa_pkg::BPA_ADDR_W-1:0]   in_page_address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bpa_pkg::BPA_ADDR_W-1:0]        out_alloc_address,
  output logic [bpa_pkg::BPA_STS_W-1:0]         out_status,
  input  wire logic [bpa_pkg::BPA_ADDR_W-1:0]   region_base,
  input  wire logic [bpa_pkg::BPA_PCNT_W-1:0]   page_count,
  output bpa_pkg::bpa_acc_t                     acc,
  output logic [WIDX_W-1:0]                     acc_idx,
  output logic [63:0]                           mem_wdata,
  input  wire logic [63:0]                      mem_rdata,
  input  wire bpa_pkg::bpa_sum_sts_t            sum_sts,
  input  wire logic [WIDX_W-1:0]                found_idx
);
  import bpa_pkg::*;

  localparam int P_W    = WIDX_W + 6;
  localparam int N_W    = P_W + 1;
  localparam int PB_SH  = $clog2(PAGE_BYTES);
  localparam int RES_SH = PB_SH + 3;
  localparam int EXT_W  = N_W + RES_SH;

  bpa_state_t         state_r, state_nxt;
  logic [N_W-1:0]     n_r, res_r, live_n, res_calc;
  logic [EXT_W-1:0]   res_ext;
  logic [63:0]        addr_r, diff_r, res_addr_r, out_addr_r;
  logic               below_r;
  logic [WIDX_W-1:0]  widx_r;
  logic [5:0]         bit_r;
  logic [WIDX_W:0]    w_r, res_hi, n_hi;
  logic [P_W-1:0]     p_r, p_cand;
  bpa_status_t        res_status_r, out_status_r;
  logic               out_valid_r, out_free;

  logic               sweep_end, alc_miss, p_bad, fr_range;
  logic [63:0]        ge_mask, lt_mask, init_free, rd_word, free_bits, alc_word, idx_full;
  logic [5:0]         low_b;

  // page count saturated at the store size, and pages that hold the bitmap itself
  always_comb begin
    live_n   = (32'(page_count) > 32'(MAX_PAGES)) ? N_W'(MAX_PAGES) : N_W'(page_count);
    res_ext  = (EXT_W'(live_n) + EXT_W'((64'd1 << RES_SH) - 64'd1)) >> RES_SH;
    res_calc = N_W'(res_ext);
  end

  always_comb begin
    res_hi    = res_r[N_W-1:6];
    n_hi      = n_r[N_W-1:6];
    sweep_end = {w_r, 6'b0} >= n_r;
    ge_mask   = (w_r > res_hi) ? {64{1'b1}} :
                (w_r == res_hi) ? ({64{1'b1}} << res_r[5:0]) : 64'd0;
    lt_mask   = (w_r < n_hi) ? {64{1'b1}} :
                (w_r == n_hi) ? ~({64{1'b1}} << n_r[5:0]) : 64'd0;
    init_free = ge_mask & lt_mask;

    alc_miss  = !sum_sts.found || ({1'b0, found_idx, 6'b0} >= n_r);
    rd_word   = sum_sts.nonfull ? mem_rdata : {64{1'b1}};
    free_bits = ~rd_word;
    low_b     = bpa_lowest_set(free_bits);
    p_cand    = {widx_r, low_b};
    p_bad     = (free_bits == 64'd0) || ({1'b0, p_cand} >= n_r);
    alc_word  = rd_word | (64'd1 << low_b);

    idx_full  = diff_r >> PB_SH;
    fr_range  = below_r || (idx_full >= 64'(n_r));
    out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            OP_INIT:  state_nxt = S_INIT_CLR;
            OP_ALLOC: state_nxt = S_ALC_SRCH1;
            OP_FREE:  state_nxt = S_FREE_SUB;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT_CLR:   state_nxt = S_INIT_SWEEP;
      S_INIT_SWEEP: if (sweep_end) state_nxt = S_DONE;
      S_ALC_SRCH1:  state_nxt = S_ALC_SRCH2;
      S_ALC_SRCH2:  state_nxt = S_ALC_READ;
      S_ALC_READ:   state_nxt = alc_miss ? S_DONE : S_ALC_MOD;
      S_ALC_MOD:    state_nxt = p_bad ? S_DONE : S_ALC_ADDR;
      S_ALC_ADDR:   state_nxt = S_DONE;
      S_FREE_SUB:   state_nxt = S_FREE_CHK;
      S_FREE_CHK:   state_nxt = fr_range ? S_DONE : S_FREE_MOD;
      S_FREE_MOD:   state_nxt = S_DONE;
      S_DONE:       if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    acc       = '0;
    acc_idx   = '0;
    mem_wdata = '0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_INIT_CLR: acc.clr_all = 1'b1;
      S_INIT_SWEEP: begin
        if (!sweep_end) begin
          acc.we      = 1'b1;
          acc.nonfull = |init_free;
          acc_idx     = w_r[WIDX_W-1:0];
          mem_wdata   = ~init_free;
        end
      end
      S_ALC_READ: begin
        if (!alc_miss) begin
          acc.re  = 1'b1;
          acc_idx = found_idx;
        end
      end
      S_ALC_MOD: begin
        if (!p_bad) begin
          acc.we      = 1'b1;
          acc.nonfull = ~&alc_word;
          acc_idx     = widx_r;
          mem_wdata   = alc_word;
        end
      end
      S_FREE_CHK: begin
        if (!fr_range) begin
          acc.re  = 1'b1;
          acc_idx = idx_full[P_W-1:6];
        end
      end
      S_FREE_MOD: begin
        acc.we      = 1'b1;
        acc.nonfull = 1'b1;
        acc_idx     = widx_r;
        mem_wdata   = rd_word & ~(64'd1 << bit_r);
      end
      S_ALC_SRCH1, S_ALC_SRCH2, S_ALC_ADDR, S_FREE_SUB, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      res_r       <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= live_n;
      res_r   <= res_calc;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        addr_r       <= in_page_address;
        res_addr_r   <= 64'd0;
        res_status_r <= STS_OK;
      end
      S_INIT_CLR:   w_r <= '0;
      S_INIT_SWEEP: w_r <= w_r + 1'b1;
      S_ALC_READ: begin
        widx_r <= found_idx;
        if (alc_miss) res_status_r <= STS_NOMEM;
      end
      S_ALC_MOD: begin
        p_r <= p_cand;
        if (p_bad) res_status_r <= STS_NOMEM;
      end
      S_ALC_ADDR: res_addr_r <= region_base + (64'(p_r) << PB_SH);
      S_FREE_SUB: begin
        below_r <= addr_r < region_base;
        diff_r  <= addr_r - region_base;
      end
      S_FREE_CHK: begin
        widx_r <= idx_full[P_W-1:6];
        bit_r  <= idx_full[5:0];
        if (fr_range) res_status_r <= STS_RANGE;
      end
      S_DONE: begin
        if (out_free) begin
          out_addr_r   <= res_addr_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_addr_r;
  assign out_status        = out_status_r;

endmodule
`default_nettype wire

FILE: design/bitmap_page_allocator_top.sv
`default_nettype none
// First-fit physical page allocator over one used bit per page, kept as 64-bit words in a
// single-port synchronous RAM next to one non-full flag per word; a cleared flag means the
// word reads as all used, so no clearing pass runs after reset and the block takes items at
// once. Transactions are handled one at a time and the result sits in an output register,
// so a new item is taken while the last result waits. An alloc runs a two-stage search of
// the non-full flags, one RAM read, modify and write back, an address add and a result load,
// and ends early when out of memory; a free runs subtract and range check, RAM read and write
// back; init sets ceil(n/64) bitmap words, with n the page count held to MAX_PAGES, by writing
// one bitmap word per cycle. PAGE_BYTES must be a power of two.
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES  = bpa_pkg::BPA_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::BPA_PAGE_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bpa_in_if.sink                                 in_chan,
  bpa_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [bpa_pkg::BPA_CIDX_W-1:0]    cfg_index,
  input  wire logic [bpa_pkg::BPA_ADDR_W-1:0]    cfg_wdata
);
  import bpa_pkg::*;

  localparam int WORDS  = (MAX_PAGES + 63) / 64;
  localparam int WIDX_W = ($clog2(WORDS) > 7) ? $clog2(WORDS) : 7;

  logic [BPA_ADDR_W-1:0] region_base_r;
  logic [BPA_PCNT_W-1:0] page_count_r;

  bpa_acc_t          acc;
  logic [WIDX_W-1:0] acc_idx;
  logic [63:0]       mem_wdata, mem_rdata;
  bpa_sum_sts_t      sum_sts;
  logic [WIDX_W-1:0] found_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      page_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_BASE: region_base_r <= cfg_wdata;
        CFG_PAGE_COUNT:  page_count_r  <= cfg_wdata[BPA_PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  bpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .WIDX_W     (WIDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_opcode         (in_chan.opcode),
    .in_page_address   (in_chan.page_address),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_alloc_address (out_chan.alloc_address),
    .out_status        (out_chan.status),
    .region_base       (region_base_r),
    .page_count        (page_count_r),
    .acc               (acc),
    .acc_idx           (acc_idx),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata),
    .sum_sts           (sum_sts),
    .found_idx         (found_idx)
  );

  bpa_summary #(
    .WIDX_W (WIDX_W)
  ) u_summary (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .acc_idx   (acc_idx),
    .sts       (sum_sts),
    .found_idx (found_idx)
  );

  bpa_bitmap_mem #(
    .WIDX_W (WIDX_W)
  ) u_mem (
    .clk     (clk),
    .acc     (acc),
    .acc_idx (acc_idx),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while a transaction is in flight");

  a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == STS_NOMEM) |-> (out_chan.alloc_address == '0))
    else $error("out of memory result carries an address");

  // the non-full flag must track the word being written
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    acc.we |-> (acc.nonfull == (mem_wdata != {64{1'b1}})))
    else $error("non-full flag disagrees with written word");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    acc.re |=> !acc.re && !acc.clr_all)
    else $error("bitmap read not followed by its modify cycle");

endmodule
`default_nettype wire
